// ===== rtl/core/rrm_pkg.sv =====
package rrm_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WAITER_W   = 16;
  localparam int unsigned IN_DATA_W  = KEY_W + WORD_W + WAITER_W;
  localparam int unsigned OUT_DATA_W = WORD_W + WAITER_W;

  // action codes carried on the input tuser
  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_RECV = 1'b1;

  typedef enum logic [1:0] {
    ST_QUEUED     = 2'd0,
    ST_MATCHED    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_LOOK   = 4'b0010,
    FSM_DECIDE = 4'b0100,
    FSM_POP    = 4'b1000
  } fsm_e;

endpackage

// ===== rtl/core/send_recv_rendezvous_matcher_top.sv =====
// channel   | dir | tdata (low bit up)                         | tuser
// ----------+-----+--------------------------------------------+------------------
// s_axis    | in  | key[63:0], value[127:64], waiter_id[143:128] | action (0 send)
// m_axis    | out | matched_value[63:0], matched_waiter[79:64]  | status[1:0]
//
// one item is in flight at a time; a result that queues or is dropped is loaded after the compare
// register and the decide step, and a match also waits for the entry memory read after the decide step
// the next beat is accepted at the earliest on the edge after the result is loaded, so the
// matcher takes no new item until the result of the last one is loaded
// rst_ni clears slot busy bits and per-slot fifo state; keys and entries need no reset
// a stalled output holds the decide step until the output register frees up
module send_recv_rendezvous_matcher_top #(
  parameter int unsigned KEY_SLOTS   = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // key, value, waiter_id
  input  logic                          s_axis_tuser,   // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // matched_value, matched_waiter
  output logic [1:0]                    m_axis_tuser    // status
);
  import rrm_pkg::*;

  localparam int unsigned SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRIES = KEY_SLOTS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // captured input beat
  fsm_e                state_q, state_d;
  logic                action_q;
  logic [KEY_W-1:0]    key_q;
  logic [WORD_W-1:0]   value_q;
  logic [WAITER_W-1:0] waiter_q;

  // per-slot fifo bookkeeping, read at one slot per item
  logic              holds_sends_q [KEY_SLOTS];
  logic [HEAD_W-1:0] head_q        [KEY_SLOTS];
  logic [CNT_W-1:0]  count_q       [KEY_SLOTS];

  logic              meta_we;
  logic [SLOT_W-1:0] meta_idx;
  logic              meta_holds_d;
  logic [HEAD_W-1:0] meta_head_d;
  logic [CNT_W-1:0]  meta_cnt_d;

  // key table
  logic              kt_set, kt_clr;
  logic              kt_hit, kt_free;
  logic [SLOT_W-1:0] kt_hit_idx, kt_free_idx;

  // entry memory
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  // output register
  logic                m_valid_q;
  status_e             m_status_q;
  logic [WORD_W-1:0]   m_value_q;
  logic [WAITER_W-1:0] m_waiter_q;
  logic                out_load;
  status_e             out_status;
  logic [WORD_W-1:0]   out_value;
  logic [WAITER_W-1:0] out_waiter;

  logic                in_beat, out_free, is_send;
  logic [WORD_W-1:0]   word;
  logic                cur_holds;
  logic [HEAD_W-1:0]   cur_head;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W:0]      tail_sum;
  logic [HEAD_W-1:0]   tail_pos;
  logic [HEAD_W-1:0]   next_head;

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign is_send       = (action_q == ACT_SEND);
  assign word          = is_send ? value_q : {{(WORD_W - WAITER_W){1'b0}}, waiter_q};

  rrm_key_table #(
    .NUM   (KEY_SLOTS),
    .IDX_W (SLOT_W)
  ) u_key_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_q),
    .set_en_i   (kt_set),
    .set_idx_i  (kt_free_idx),
    .clr_en_i   (kt_clr),
    .clr_idx_i  (kt_hit_idx),
    .hit_o      (kt_hit),
    .hit_idx_o  (kt_hit_idx),
    .free_o     (kt_free),
    .free_idx_o (kt_free_idx)
  );

  rrm_entry_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // fifo state of the slot that owns the key
  assign cur_holds = holds_sends_q[kt_hit_idx];
  assign cur_head  = head_q[kt_hit_idx];
  assign cur_cnt   = count_q[kt_hit_idx];

  // tail position: head + count stays below twice the depth, one subtract wraps it
  always_comb begin
    tail_sum = (CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_cnt);
    if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    tail_pos = tail_sum[HEAD_W-1:0];
  end

  assign next_head = (cur_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + HEAD_W'(1);

  always_comb begin
    state_d      = state_q;
    kt_set       = 1'b0;
    kt_clr       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    mem_wdata    = word;
    meta_we      = 1'b0;
    meta_idx     = kt_hit_idx;
    meta_holds_d = is_send;
    meta_head_d  = cur_head;
    meta_cnt_d   = cur_cnt;
    out_load     = 1'b0;
    out_status   = ST_QUEUED;
    out_value    = '0;
    out_waiter   = '0;

    case (state_q)
      FSM_IDLE: begin
        if (in_beat) begin
          state_d = FSM_LOOK;
        end
      end
      FSM_LOOK: begin
        state_d = FSM_DECIDE;
      end
      FSM_DECIDE: begin
        if (out_free) begin
          state_d = FSM_IDLE;
          if (!kt_hit) begin
            if (!kt_free) begin
              out_load   = 1'b1;
              out_status = ST_TABLE_FULL;
            end else begin
              // claim the lowest free slot and start its fifo with this item
              kt_set       = 1'b1;
              meta_we      = 1'b1;
              meta_idx     = kt_free_idx;
              meta_head_d  = '0;
              meta_cnt_d   = CNT_W'(1);
              mem_we       = 1'b1;
              mem_waddr    = ADDR_W'(kt_free_idx) * ADDR_W'(QUEUE_DEPTH);
              out_load     = 1'b1;
              out_status   = ST_QUEUED;
            end
          end else if (cur_holds != is_send) begin
            // opposite kind waits: pop the oldest entry
            mem_re       = 1'b1;
            mem_raddr    = ADDR_W'(kt_hit_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);
            meta_we      = 1'b1;
            meta_holds_d = cur_holds;
            meta_cnt_d   = cur_cnt - CNT_W'(1);
            if (cur_cnt == CNT_W'(1)) begin
              kt_clr      = 1'b1;
              meta_head_d = '0;
            end else begin
              meta_head_d = next_head;
            end
            state_d = FSM_POP;
          end else if (cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
            out_load   = 1'b1;
            out_status = ST_QUEUE_FULL;
          end else begin
            meta_we    = 1'b1;
            meta_cnt_d = cur_cnt + CNT_W'(1);
            mem_we     = 1'b1;
            mem_waddr  = ADDR_W'(kt_hit_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
            out_load   = 1'b1;
            out_status = ST_QUEUED;
          end
        end
      end
      FSM_POP: begin
        // output register was free when the read issued, so load now
        out_load   = 1'b1;
        out_status = ST_MATCHED;
        out_value  = is_send ? value_q : mem_rdata;
        out_waiter = is_send ? mem_rdata[WAITER_W-1:0] : waiter_q;
        state_d    = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        holds_sends_q[i] <= 1'b0;
        head_q[i]        <= '0;
        count_q[i]       <= '0;
      end
    end else if (meta_we) begin
      holds_sends_q[meta_idx] <= meta_holds_d;
      head_q[meta_idx]        <= meta_head_d;
      count_q[meta_idx]       <= meta_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      action_q <= s_axis_tuser;
      key_q    <= s_axis_tdata[KEY_W-1:0];
      value_q  <= s_axis_tdata[KEY_W +: WORD_W];
      waiter_q <= s_axis_tdata[KEY_W + WORD_W +: WAITER_W];
    end
    if (out_load) begin
      m_status_q <= out_status;
      m_value_q  <= out_value;
      m_waiter_q <= out_waiter;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_waiter_q, m_value_q};
  assign m_axis_tuser  = m_status_q;

endmodule

// ===== rtl/core/rrm_key_table.sv =====
module rrm_key_table #(
  parameter int unsigned NUM   = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rrm_pkg::KEY_W-1:0] key_i,
  input  logic                     set_en_i,
  input  logic [IDX_W-1:0]         set_idx_i,
  input  logic                     clr_en_i,
  input  logic [IDX_W-1:0]         clr_idx_i,
  output logic                     hit_o,
  output logic [IDX_W-1:0]         hit_idx_o,
  output logic                     free_o,
  output logic [IDX_W-1:0]         free_idx_o
);
  import rrm_pkg::*;

  logic [KEY_W-1:0] key_q [NUM];
  logic [NUM-1:0]   busy_q;
  logic [NUM-1:0]   hit_vec_d, hit_vec_q;
  logic [NUM-1:0]   free_vec_q;

  // compare every slot at once, result registered for the next cycle
  always_comb begin
    for (int i = 0; i < NUM; i++) begin
      hit_vec_d[i] = busy_q[i] && (key_q[i] == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_en_i) begin
      key_q[set_idx_i] <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      hit_vec_q  <= '0;
      free_vec_q <= '0;
    end else begin
      hit_vec_q  <= hit_vec_d;
      free_vec_q <= ~busy_q;
      if (set_en_i) begin
        busy_q[set_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        busy_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  // keys are unique among busy slots, so the hit vector is one-hot or zero
  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = 0; i < NUM; i++) begin
      if (hit_vec_q[i]) begin
        hit_idx_o = hit_idx_o | IDX_W'(i);
      end
    end
    for (int j = NUM - 1; j >= 0; j--) begin
      if (free_vec_q[j]) begin
        free_idx_o = IDX_W'(j);
      end
    end
  end

  assign hit_o  = |hit_vec_q;
  assign free_o = |free_vec_q;

endmodule

// ===== rtl/core/rrm_entry_mem.sv =====
module rrm_entry_mem #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [rrm_pkg::WORD_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [rrm_pkg::WORD_W-1:0] rdata_o
);
  import rrm_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rrm_checker.sv =====
module rrm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import rrm_pkg::*;

  // a result waiting on a stalled sink stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // only a match carries a value and a waiter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_MATCHED) |-> (m_axis_tdata == '0))
    else $error("nonzero payload on a result without a match");

  // one item in flight: no input beat right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat accepted while an item is in flight");

  // no result is loaded by the edge that accepts a beat while the output is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early after an accepted beat");

endmodule

bind send_recv_rendezvous_matcher_top rrm_checker u_rrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/send_recv_rendezvous_matcher_top_test.sv =====
`timescale 1ns / 1ps

module send_recv_rendezvous_matcher_top_test;
  import rrm_pkg::*;

  localparam int unsigned KEY_SLOTS   = 16;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned ITEM_GOAL   = 550;
  localparam int unsigned CALM_FROM   = 480;     // no idling on either side past this
  localparam int unsigned HOLD_AT     = 150;     // long receiver hold-off starts here
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    status_e     status;
    logic [63:0] value;
    logic [15:0] waiter;
  } outcome_t;

  // mirror of the slot table and per-key fifos, one outcome per accepted beat
  class rendezvous_tracker;
    bit [63:0] slot_key [KEY_SLOTS];
    bit        slot_busy [KEY_SLOTS];
    bit        slot_sends [KEY_SLOTS];
    int        slot_head [KEY_SLOTS];
    int        slot_count [KEY_SLOTS];
    bit [63:0] entry_word [KEY_SLOTS*QUEUE_DEPTH];
    outcome_t  due_outcomes [$];
    int        errors;

    function void note_offer(logic act, bit [63:0] key, bit [63:0] value, bit [15:0] waiter);
      outcome_t  o;
      int        found;
      int        free_idx;
      int        pos;
      bit        is_send;
      bit [63:0] word;
      bit [63:0] popped;
      is_send  = (act == ACT_SEND);
      word     = is_send ? value : {48'd0, waiter};
      o.status = ST_QUEUED;
      o.value  = '0;
      o.waiter = '0;
      found    = -1;
      free_idx = -1;
      for (int s = 0; s < KEY_SLOTS; s++) begin
        if (slot_busy[s]) begin
          if (found < 0 && slot_key[s] == key) found = s;
        end else if (free_idx < 0) begin
          free_idx = s;
        end
      end
      if (found < 0) begin
        if (free_idx < 0) begin
          o.status = ST_TABLE_FULL;
        end else begin
          // claim the lowest free slot and start its fifo
          slot_key[free_idx]   = key;
          slot_busy[free_idx]  = 1'b1;
          slot_sends[free_idx] = is_send;
          slot_head[free_idx]  = 0;
          slot_count[free_idx] = 1;
          entry_word[free_idx*QUEUE_DEPTH] = word;
        end
      end else if (slot_sends[found] != is_send) begin
        // opposite kind waiting: pop the oldest one
        popped = entry_word[found*QUEUE_DEPTH + slot_head[found]];
        slot_head[found]  = (slot_head[found] + 1) % QUEUE_DEPTH;
        slot_count[found] = slot_count[found] - 1;
        if (slot_count[found] == 0) begin
          slot_busy[found] = 1'b0;
          slot_head[found] = 0;
        end
        o.status = ST_MATCHED;
        if (is_send) begin
          o.value  = value;
          o.waiter = popped[15:0];
        end else begin
          o.value  = popped;
          o.waiter = waiter;
        end
      end else if (slot_count[found] >= QUEUE_DEPTH) begin
        o.status = ST_QUEUE_FULL;
      end else begin
        pos = (slot_head[found] + slot_count[found]) % QUEUE_DEPTH;
        entry_word[found*QUEUE_DEPTH + pos] = word;
        slot_count[found] = slot_count[found] + 1;
      end
      due_outcomes.insert(due_outcomes.size(), o);
    endfunction

    function void check_outcome(logic [1:0] status, logic [63:0] value, logic [15:0] waiter);
      outcome_t o;
      if (due_outcomes.size() == 0) begin
        $error("result beat with no outcome pending: status %0d", status);
        errors++;
        return;
      end
      o = due_outcomes[0];
      due_outcomes.delete(0);
      if (status !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, status);
        errors++;
      end
      if (value !== o.value) begin
        $error("matched_value: expected %h, got %h", o.value, value);
        errors++;
      end
      if (waiter !== o.waiter) begin
        $error("matched_waiter: expected %h, got %h", o.waiter, waiter);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // key, value, waiter_id
  logic                  s_axis_tuser;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // matched_value, matched_waiter
  logic [1:0]            m_axis_tuser;   // status

  rendezvous_tracker board = new();
  int unsigned       items_sent;
  int unsigned       cycle_count;
  bit                calm;
  bit                tx_choppy;
  bit                hold_done;

  send_recv_rendezvous_matcher_top #(
    .KEY_SLOTS   (KEY_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side: every accepted beat is checked against the oldest outcome
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_outcome(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[79:64]);
  end

  // receiver: random stall bursts, one long hold-off so the block backs up
  initial begin
    bit rx_choppy;
    rx_choppy     = 1'b1;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) == 0) rx_choppy = !rx_choppy;
      if (!hold_done && items_sent >= HOLD_AT) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && rx_choppy && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic sender_pause(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // one input beat, held until accepted, then noted in the tracker
  task automatic offer_beat(logic act, logic [63:0] key, logic [63:0] value,
                            logic [15:0] waiter);
    if (items_sent >= ITEM_GOAL) return;
    if (!calm && tx_choppy && $urandom_range(0, 3) == 0)
      sender_pause($urandom_range(1, 17));
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {waiter, value, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_offer(act, key, value, waiter);
    items_sent++;
    calm = (items_sent >= CALM_FROM);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_act();
    return $urandom_range(0, 1) ? ACT_RECV : ACT_SEND;
  endfunction

  // empty every busy slot with the opposite kind
  task automatic drain_slots();
    logic [63:0] keys [KEY_SLOTS];
    logic        acts [KEY_SLOTS];
    int          counts [KEY_SLOTS];
    for (int s = 0; s < KEY_SLOTS; s++) begin
      keys[s]   = board.slot_key[s];
      acts[s]   = board.slot_sends[s] ? ACT_RECV : ACT_SEND;
      counts[s] = board.slot_busy[s] ? board.slot_count[s] : 0;
    end
    for (int s = 0; s < KEY_SLOTS; s++)
      repeat (counts[s]) offer_beat(acts[s], keys[s], rand64(), 16'($urandom));
  endtask

  // a few keys, random mix of sends and receives
  task automatic pool_run();
    logic [63:0] keys [4];
    int          npool;
    int          len;
    int          send_pct;
    npool    = $urandom_range(1, 4);
    len      = $urandom_range(8, 30);
    send_pct = 25 * $urandom_range(1, 3);
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0:       keys[i] = '0;
        1:       keys[i] = '1;
        default: keys[i] = rand64();
      endcase
    end
    repeat (len)
      offer_beat(($urandom_range(0, 99) < send_pct) ? ACT_SEND : ACT_RECV,
                 keys[$urandom_range(0, npool - 1)], rand64(), 16'($urandom));
  endtask

  // pile up six to eleven of one kind on a key, at times past its depth, then pop with the other kind
  task automatic flood_run();
    logic [63:0] key;
    logic        act;
    key = rand64();
    act = rand_act();
    repeat ($urandom_range(6, 11)) offer_beat(act, key, rand64(), 16'($urandom));
    repeat ($urandom_range(3, 12)) offer_beat(!act, key, rand64(), 16'($urandom));
  endtask

  // many fresh keys, at times enough to run out of slots, then drain them
  task automatic fill_run();
    repeat ($urandom_range(12, 19)) offer_beat(rand_act(), rand64(), rand64(), 16'($urandom));
    drain_slots();
  endtask

  initial begin
    logic [63:0] deep_key;
    items_sent    = 0;
    calm          = 1'b0;
    tx_choppy     = 1'b1;
    hold_done     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = ACT_SEND;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes of key, value and waiter; ignored fields set to their maximum or to an alternating pattern
    offer_beat(ACT_SEND, '0, '1, 16'hFFFF);
    offer_beat(ACT_RECV, '0, 64'h5555_5555_5555_5555, 16'hFFFF);
    offer_beat(ACT_RECV, '1, '1, 16'h0000);
    offer_beat(ACT_SEND, '1, '0, 16'hFFFF);
    // two receivers wait, sends pop them oldest first and free the slot
    offer_beat(ACT_RECV, '1, '0, 16'h8001);
    offer_beat(ACT_RECV, '1, '0, 16'h7FFE);
    offer_beat(ACT_SEND, '1, 64'hA5A5_5A5A_0F0F_F0F0, 16'h0000);
    offer_beat(ACT_SEND, '1, 64'h8000_0000_0000_0001, 16'h1234);
    // fill one key's fifo, then one more send is dropped as queue full
    deep_key = 64'h8000_0000_0000_0001;
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      offer_beat(ACT_SEND, deep_key, 64'(i) << (7 * i), 16'hFFFF);
    offer_beat(ACT_RECV, deep_key, '1, 16'hC3C3);
    drain_slots();

    while (items_sent < ITEM_GOAL) begin
      tx_choppy = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        6, 7:    flood_run();
        8:       fill_run();
        9:       offer_beat(rand_act(), rand64(), rand64(), 16'($urandom));
        default: pool_run();
      endcase
      if ($urandom_range(0, 3) == 0) drain_slots();
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.due_outcomes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
